/* hw/rtl/imd_pkg.sv */
// Shared types and constants for the ICY metadata deframer.
package imd_pkg;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_LEN   = 2'd1,
    KIND_TEXT  = 2'd2
  } byte_kind_e;

  typedef enum logic [1:0] {
    REG_META_INTERVAL = 2'd0,
    REG_CHUNK_BYTES   = 2'd1,
    REG_META_LIMIT    = 2'd2
  } cfg_reg_e;

  localparam int unsigned IntervalW = 20;
  localparam int unsigned CountW    = 12;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [IntervalW-1:0] MetaIntervalRst = 20'd16000;
  localparam logic [CountW-1:0]    ChunkBytesRst   = 12'd1152;
  localparam logic [CountW-1:0]    MetaLimitRst    = 12'd256;

  typedef struct packed {
    logic [7:0] data;
    byte_kind_e kind;
    logic       meta_last;
    logic       meta_oversize;
    logic       chunk_last;
  } result_t;

endpackage

/* hw/rtl/icy_metadata_deframer_core.sv */
// ICY metadata deframer: tags each stream byte as audio, length or metadata text.
//
// One byte can enter per cycle and its tagged copy appears in an output register
// in the next cycle; a new transaction is taken whenever that register is empty
// or being drained, so the sustained rate is one byte per cycle while out_ready_i
// stays high. Every meta_interval audio bytes the next byte is a length L and
// the following L*16 bytes are text; meta_last marks the final text byte,
// meta_oversize marks the length and text bytes of a block above meta_limit,
// and chunk_last marks every chunk_bytes-th audio byte. Register writes take
// effect on the next byte and leave the counters untouched.
module icy_metadata_deframer_core
  import imd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           byte_out_o,
  output logic [1:0]           byte_kind_o,
  output logic                 meta_last_o,
  output logic                 meta_oversize_o,
  output logic                 chunk_last_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [IntervalW-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    PH_AUDIO = 2'd0,
    PH_LEN   = 2'd1,
    PH_TEXT  = 2'd2,
    PH_SPARE = 2'd3
  } phase_e;

  logic [IntervalW-1:0] meta_interval_q;
  logic [CountW-1:0]    chunk_bytes_q, meta_limit_q;

  phase_e               phase_q, phase_d;
  logic [IntervalW-1:0] audio_count_q, audio_count_d;
  logic [CountW-1:0]    meta_rem_q, meta_rem_d;
  logic [CountW-1:0]    chunk_count_q, chunk_count_d;
  logic                 oversize_q, oversize_d;

  logic                 out_valid_q;
  result_t              res_q, res_d;
  logic                 in_fire;

  logic [CountW-1:0]    len;
  logic [CountW-1:0]    rem_dec;
  logic [CountW-1:0]    chunk_inc;
  logic [IntervalW-1:0] audio_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign len       = {data_byte_i, 4'b0000};
  assign rem_dec   = meta_rem_q - CountW'(1);
  assign chunk_inc = chunk_count_q + CountW'(1);
  assign audio_inc = audio_count_q + IntervalW'(1);

  always_comb begin
    phase_d       = phase_q;
    audio_count_d = audio_count_q;
    meta_rem_d    = meta_rem_q;
    chunk_count_d = chunk_count_q;
    oversize_d    = oversize_q;
    res_d.data          = data_byte_i;
    res_d.kind          = KIND_AUDIO;
    res_d.meta_last     = 1'b0;
    res_d.meta_oversize = 1'b0;
    res_d.chunk_last    = 1'b0;
    unique case (phase_q)
      PH_LEN: begin
        res_d.kind          = KIND_LEN;
        oversize_d          = len > meta_limit_q;
        res_d.meta_oversize = len > meta_limit_q;
        meta_rem_d          = len;
        phase_d             = (len != '0) ? PH_TEXT : PH_AUDIO;
      end
      PH_TEXT: begin
        res_d.kind          = KIND_TEXT;
        res_d.meta_oversize = oversize_q;
        meta_rem_d          = rem_dec;
        if (rem_dec == '0) begin
          res_d.meta_last = 1'b1;
          oversize_d      = 1'b0;
          phase_d         = PH_AUDIO;
        end
      end
      PH_AUDIO, PH_SPARE: begin
        phase_d = PH_AUDIO;
        if (chunk_inc == chunk_bytes_q) begin
          res_d.chunk_last = 1'b1;
          chunk_count_d    = '0;
        end else begin
          chunk_count_d = chunk_inc;
        end
        if (audio_inc >= meta_interval_q) begin
          audio_count_d = '0;
          phase_d       = PH_LEN;
        end else begin
          audio_count_d = audio_inc;
        end
      end
      default: phase_d = PH_AUDIO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_interval_q <= MetaIntervalRst;
      chunk_bytes_q   <= ChunkBytesRst;
      meta_limit_q    <= MetaLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_META_INTERVAL: meta_interval_q <= cfg_wdata_i;
        REG_CHUNK_BYTES:   chunk_bytes_q   <= cfg_wdata_i[CountW-1:0];
        REG_META_LIMIT:    meta_limit_q    <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_AUDIO;
      audio_count_q <= '0;
      meta_rem_q    <= '0;
      chunk_count_q <= '0;
      oversize_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q       <= phase_d;
        audio_count_q <= audio_count_d;
        meta_rem_q    <= meta_rem_d;
        chunk_count_q <= chunk_count_d;
        oversize_q    <= oversize_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_out_o      = res_q.data;
  assign byte_kind_o     = res_q.kind;
  assign meta_last_o     = res_q.meta_last;
  assign meta_oversize_o = res_q.meta_oversize;
  assign chunk_last_o    = res_q.chunk_last;

  // oversize only lives inside a text block
  a_oversize_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oversize_q |-> phase_q == PH_TEXT)
    else $error("oversize set outside text phase");

  a_meta_last_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && meta_last_o |-> byte_kind_o == KIND_TEXT)
    else $error("meta_last on non-text byte");

  a_chunk_last_audio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chunk_last_o |-> byte_kind_o == KIND_AUDIO)
    else $error("chunk_last on non-audio byte");

  a_block_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_TEXT && meta_rem_q == CountW'(1)
      |=> phase_q == PH_AUDIO && out_valid_o && meta_last_o)
    else $error("text block did not close");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");

endmodule

/* tb/sv/imd_stream_checker.sv */
// Checker for the ICY metadata deframer: tags accepted bytes and compares results.
module imd_stream_checker
  import imd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [7:0]           byte_out_i,
  input  logic [1:0]           byte_kind_i,
  input  logic                 meta_last_i,
  input  logic                 meta_oversize_i,
  input  logic                 chunk_last_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [IntervalW-1:0] cfg_wdata_i,
  output int unsigned          mismatch_cnt_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    SEG_AUDIO = 2'd0,
    SEG_LEN   = 2'd1,
    SEG_TEXT  = 2'd2
  } seg_e;

  logic [IntervalW-1:0] interval_q;
  logic [CountW-1:0]    chunk_q;
  logic [CountW-1:0]    limit_q;

  seg_e                 seg;
  logic [IntervalW-1:0] audio_seen;
  logic [CountW-1:0]    text_left;
  logic [CountW-1:0]    chunk_seen;
  logic                 oversize_q;

  result_t     tagged_q[$];
  int unsigned n_mismatch;

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
    n_mismatch     = 0;
  end

  function automatic result_t tag_byte(input logic [7:0] b);
    result_t          r;
    logic [CountW-1:0] blk_len;
    r.data          = b;
    r.kind          = KIND_AUDIO;
    r.meta_last     = 1'b0;
    r.meta_oversize = 1'b0;
    r.chunk_last    = 1'b0;
    case (seg)
      SEG_LEN: begin
        blk_len         = {b, 4'h0};
        r.kind          = KIND_LEN;
        oversize_q      = (blk_len > limit_q);
        r.meta_oversize = oversize_q;
        text_left       = blk_len;
        seg             = (blk_len != '0) ? SEG_TEXT : SEG_AUDIO;
      end
      SEG_TEXT: begin
        r.kind          = KIND_TEXT;
        r.meta_oversize = oversize_q;
        text_left       = text_left - 1'b1;
        if (text_left == '0) begin
          r.meta_last = 1'b1;
          oversize_q  = 1'b0;
          seg         = SEG_AUDIO;
        end
      end
      default: begin
        // unused state value behaves as audio
        seg        = SEG_AUDIO;
        chunk_seen = chunk_seen + 1'b1;
        if (chunk_seen == chunk_q) begin
          r.chunk_last = 1'b1;
          chunk_seen   = '0;
        end
        audio_seen = audio_seen + 1'b1;
        if (audio_seen >= interval_q) begin
          audio_seen = '0;
          seg        = SEG_LEN;
        end
      end
    endcase
    return r;
  endfunction

  task automatic cmp(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_mismatch++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      interval_q = MetaIntervalRst;
      chunk_q    = ChunkBytesRst;
      limit_q    = MetaLimitRst;
      seg        = SEG_AUDIO;
      audio_seen = '0;
      text_left  = '0;
      chunk_seen = '0;
      oversize_q = 1'b0;
      tagged_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (tagged_q.size() == 0) begin
          $error("result transaction with none pending: byte_out %0d", byte_out_i);
          n_mismatch++;
        end else begin
          want = tagged_q.pop_front();
          cmp("byte_out", want.data, byte_out_i);
          cmp("byte_kind", 8'(want.kind), 8'(byte_kind_i));
          cmp("meta_last", 8'(want.meta_last), 8'(meta_last_i));
          cmp("meta_oversize", 8'(want.meta_oversize), 8'(meta_oversize_i));
          cmp("chunk_last", 8'(want.chunk_last), 8'(chunk_last_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        tagged_q.push_back(tag_byte(data_byte_i));
      end
      // writes apply from the next byte on
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_META_INTERVAL: interval_q = cfg_wdata_i;
          REG_CHUNK_BYTES:   chunk_q    = cfg_wdata_i[CountW-1:0];
          REG_META_LIMIT:    limit_q    = cfg_wdata_i[CountW-1:0];
          default: ;
        endcase
      end
    end
    mismatch_cnt_o <= n_mismatch;
    pending_o      <= tagged_q.size();
  end

endmodule

/* tb/sv/tb_icy_metadata_deframer_core.sv */
// Top-level testbench for icy_metadata_deframer_core: stimulus, flow control and verdict.
module tb_icy_metadata_deframer_core;
  import imd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldAfter  = 300;
  localparam int unsigned HoldCycles = 400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           data_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [7:0]           byte_out_o;
  logic [1:0]           byte_kind_o;
  logic                 meta_last_o;
  logic                 meta_oversize_o;
  logic                 chunk_last_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [IntervalW-1:0] cfg_wdata_i;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  int unsigned burst_left;
  int unsigned gap_len;

  // stream position as the generator sees it, to place length bytes
  byte_kind_e           slot;
  logic [IntervalW-1:0] gen_interval;
  logic [IntervalW-1:0] gen_audio;
  logic [CountW-1:0]    gen_text;

  icy_metadata_deframer_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .out_valid_o,
    .out_ready_i,
    .byte_out_o,
    .byte_kind_o,
    .meta_last_o,
    .meta_oversize_o,
    .chunk_last_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  imd_stream_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .data_byte_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .byte_out_i      (byte_out_o),
    .byte_kind_i     (byte_kind_o),
    .meta_last_i     (meta_last_o),
    .meta_oversize_i (meta_oversize_o),
    .chunk_last_i    (chunk_last_o),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_o       (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial cycle_cnt = 0;
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("tb_icy_metadata_deframer_core failed");
    $finish;
  end

  initial begin : sink
    int unsigned mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk_i);
        if (!held && sent_cnt >= HoldAfter) begin
          // long hold-off so the output register fills and input stalls
          held = 1'b1;
          out_ready_i <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
        end else begin
          case (mode)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= ($urandom_range(0, 3) != 0);
            2:       out_ready_i <= ~out_ready_i;
            default: out_ready_i <= ($urandom_range(0, 1) != 0);
          endcase
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      if (gap_len > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap_len    = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 10)
                                               : $urandom_range(0, 3);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
    case (slot)
      KIND_LEN: begin
        gen_text = {b, 4'h0};
        slot     = (gen_text != '0) ? KIND_TEXT : KIND_AUDIO;
      end
      KIND_TEXT: begin
        gen_text = gen_text - 1'b1;
        if (gen_text == '0) slot = KIND_AUDIO;
      end
      default: begin
        gen_audio = gen_audio + 1'b1;
        if (gen_audio >= gen_interval) begin
          gen_audio = '0;
          slot      = KIND_LEN;
        end
      end
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [IntervalW-1:0] interval, input logic [IntervalW-1:0] chunk,
                          input logic [IntervalW-1:0] limit);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_META_INTERVAL;
    cfg_wdata_i <= interval;
    @(posedge clk_i);
    cfg_index_i <= REG_CHUNK_BYTES;
    cfg_wdata_i <= chunk;
    @(posedge clk_i);
    cfg_index_i <= REG_META_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gen_interval = interval;
  endtask

  task automatic send_random(input int unsigned n);
    int unsigned r;
    logic [7:0]  b;
    repeat (n) begin
      b = 8'($urandom);
      if (slot == KIND_LEN) begin
        r = $urandom_range(0, 99);
        if (r < 30)      b = 8'd0;
        else if (r < 80) b = 8'($urandom_range(1, 2));
        else if (r < 96) b = 8'($urandom_range(3, 16));
        else if (r < 98) b = 8'($urandom_range(17, 254));
        else             b = 8'hFF;
      end
      send_byte(b);
    end
  endtask

  initial begin : stimulus
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_META_INTERVAL;
    cfg_wdata_i <= '0;
    sent_cnt     = 0;
    burst_left   = 0;
    gap_len      = 0;
    slot         = KIND_AUDIO;
    gen_interval = MetaIntervalRst;
    gen_audio    = '0;
    gen_text     = '0;
    wait (rst_ni);
    @(posedge clk_i);

    // zero-length block, then a 16-byte block just over the limit
    set_regs(20'd2, 20'd3, 20'd15);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h01);
    repeat (16) send_byte(8'($urandom));
    send_byte(8'h3C);

    // zero interval: a length byte after every audio byte
    set_regs(20'd0, 20'd0, 20'd4080);
    send_random(200);
    set_regs(20'hFFFFF, 20'hFFF, 20'd0);
    send_random(60);
    // interval now below the running audio count
    set_regs(20'd5, 20'd1, 20'd48);
    send_random(200);
    repeat (6) begin
      set_regs(20'($urandom_range(1, 24)),
               {8'($urandom), 12'($urandom_range(1, 40))},
               {8'($urandom), ($urandom_range(0, 3) == 0) ? 12'd4080
                                                          : 12'($urandom_range(0, 48))});
      send_random(120);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("tb_icy_metadata_deframer_core passed");
    end else begin
      $display("tb_icy_metadata_deframer_core failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/imd_pkg.sv
hw/rtl/icy_metadata_deframer_core.sv
tb/sv/imd_stream_checker.sv
tb/sv/tb_icy_metadata_deframer_core.sv
